// File: rtl/pfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, constants and helpers of the pump flow and speed supervisor.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int unsigned VAL_W   = 10;
	localparam int unsigned TIMER_W = 7;
	localparam int unsigned DIGIT_W = 5;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	localparam logic [VAL_W-1:0]   NO_TARGET = 10'd1000;
	localparam logic [VAL_W-1:0]   TOLERANCE = 10'd15;
	localparam logic [DIGIT_W-1:0] DIGIT_O   = 5'd18;

	localparam logic [VAL_W-1:0] SPEED_HIGH    = 10'd700;
	localparam logic [VAL_W-1:0] SPEED_OVER    = 10'd900;
	localparam logic [VAL_W-1:0] SPEED_RECOVER = 10'd800;
	localparam logic [VAL_W-1:0] SPEED_LOW     = 10'd650;

	localparam logic [VAL_W-1:0] BAND1_SPEED = 10'd200;
	localparam logic [VAL_W-1:0] BAND2_SPEED = 10'd400;
	localparam logic [VAL_W-1:0] BAND3_SPEED = 10'd600;
	localparam logic [VAL_W-1:0] BAND1_FLOW  = 10'd20;
	localparam logic [VAL_W-1:0] BAND2_FLOW  = 10'd50;
	localparam logic [VAL_W-1:0] BAND3_FLOW  = 10'd75;
	localparam logic [VAL_W-1:0] BAND4_FLOW  = 10'd80;

	localparam int unsigned START_TICKS_DEF      = 100;
	localparam int unsigned MISMATCH_TICKS_DEF   = 60;
	localparam int unsigned HIGH_SPEED_TICKS_DEF = 100;
	localparam int unsigned FLASH_TICKS_DEF      = 60;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		MODE_RUNNING = 2'd0,
		MODE_IDLE    = 2'd1,
		MODE_WAITING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_OFF  = 2'd1,
		CMD_ON   = 2'd2
	} cmd_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [VAL_W-1:0] motor_speed;
		logic [VAL_W-1:0] flow_rate;
		logic             sensor_fault;
		logic             stop_button;
		logic             start_button;
	} pfs_item_t;

	typedef struct packed {
		mode_t              mode;
		logic [TIMER_W-1:0] start_timer;
		logic [TIMER_W-1:0] mismatch_timer;
		logic [TIMER_W-1:0] high_speed_timer;
		logic [TIMER_W-1:0] over_speed_timer;
		logic [TIMER_W-1:0] recover_timer;
		logic [TIMER_W-1:0] low_speed_timer;
		logic               mismatch_indicated;
		logic               warning_flashing;
		logic               run_led;
		logic               warning_led;
		logic               flow_led;
		logic               error_led;
	} pfs_state_t;

	typedef struct packed {
		logic               run_led;
		logic               warning_led;
		logic               flow_led;
		logic               error_led;
		logic               sensor_error;
		cmd_t               motor_command;
		logic               display_write;
		logic [DIGIT_W-1:0] display_left;
		logic [DIGIT_W-1:0] display_right;
	} pfs_result_t;

	function automatic logic [TIMER_W-1:0] tick_up(input logic [TIMER_W-1:0] t);
		tick_up = (t == TIMER_MAX) ? t : t + 1'b1;
	endfunction

	// speed / 100, exact for ten-bit speeds
	function automatic logic [DIGIT_W-1:0] hundreds(input logic [VAL_W-1:0] s);
		logic [20:0] p;
		p = 21'(s) * 21'd1311;
		hundreds = DIGIT_W'(p >> 17);
	endfunction

	// (speed / 10) % 10, exact for ten-bit speeds
	function automatic logic [DIGIT_W-1:0] tens(input logic [VAL_W-1:0] s);
		logic [22:0] p;
		logic [6:0]  q10;
		logic [6:0]  h10;
		p   = 23'(s) * 23'd6554;
		q10 = 7'(p >> 16);
		h10 = 7'(hundreds(s)) * 7'd10;
		tens = DIGIT_W'(q10 - h10);
	endfunction

endpackage

// File: rtl/pfs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_step
// Next-state and result logic for one request against the current state.
// ----------------------------------------------------------------------------
module pfs_step #(
	parameter int unsigned START_TICKS      = pfs_pkg::START_TICKS_DEF,
	parameter int unsigned MISMATCH_TICKS   = pfs_pkg::MISMATCH_TICKS_DEF,
	parameter int unsigned HIGH_SPEED_TICKS = pfs_pkg::HIGH_SPEED_TICKS_DEF,
	parameter int unsigned FLASH_TICKS      = pfs_pkg::FLASH_TICKS_DEF
) (
	input  pfs_pkg::pfs_item_t                item,
	input  pfs_pkg::pfs_state_t               state_cur,
	input  logic [pfs_pkg::VAL_W-1:0]         target_flow,
	output pfs_pkg::pfs_state_t               state_nxt,
	output pfs_pkg::pfs_result_t              result
);
	import pfs_pkg::*;

	localparam logic [TIMER_W-1:0] START_LIM    = TIMER_W'(START_TICKS);
	localparam logic [TIMER_W-1:0] MISMATCH_LIM = TIMER_W'(MISMATCH_TICKS);
	localparam logic [TIMER_W-1:0] HIGH_LIM     = TIMER_W'(HIGH_SPEED_TICKS);
	localparam logic [TIMER_W-1:0] FLASH_LIM    = TIMER_W'(FLASH_TICKS);

	logic [VAL_W-1:0] s;
	logic [VAL_W-1:0] f;
	logic             viol;
	logic             in_tol;
	pfs_state_t       st;
	pfs_result_t      res;

	assign s = item.motor_speed;
	assign f = item.flow_rate;

	always_comb begin
		viol = 1'b0;
		if (s >= 10'd1 && s <= BAND1_SPEED && !(f >= 10'd1 && f <= BAND1_FLOW))
			viol = 1'b1;
		if (s > BAND1_SPEED && s <= BAND2_SPEED && !(f > BAND1_FLOW && f <= BAND2_FLOW))
			viol = 1'b1;
		if (s > BAND2_SPEED && s <= BAND3_SPEED && !(f > BAND2_FLOW && f <= BAND3_FLOW))
			viol = 1'b1;
		if (s > BAND3_SPEED && f > BAND4_FLOW)
			viol = 1'b1;
	end

	// unsigned window test, widened by one bit so that it cannot wrap
	assign in_tol = ({1'b0, f} + {1'b0, TOLERANCE} >= {1'b0, target_flow}) &&
		({1'b0, f} <= {1'b0, target_flow} + {1'b0, TOLERANCE});

	always_comb begin
		st  = state_cur;
		res = '0;
		if (item.operation == OP_START) begin
			st.run_led = 1'b1;
			if (target_flow == NO_TARGET) begin
				res.display_write = 1'b1;
				res.display_left  = DIGIT_O;
				res.display_right = DIGIT_O;
				st.mode           = MODE_IDLE;
			end else begin
				st.mode = MODE_WAITING;
			end
		end else if (state_cur.mode == MODE_WAITING) begin
			st.start_timer = tick_up(state_cur.start_timer);
			if (st.start_timer >= START_LIM) begin
				st.mode            = MODE_RUNNING;
				st.start_timer     = '0;
				res.motor_command  = CMD_ON;
			end
		end else if (state_cur.mode == MODE_RUNNING) begin
			if (item.sensor_fault) begin
				st.error_led     = 1'b1;
				res.sensor_error = 1'b1;
			end else if (s != '0) begin
				res.display_write = 1'b1;
				res.display_left  = hundreds(s);
				res.display_right = tens(s);

				if (viol) begin
					st.mismatch_timer = tick_up(state_cur.mismatch_timer);
					if (st.mismatch_timer >= MISMATCH_LIM) begin
						st.warning_led        = 1'b1;
						st.mismatch_indicated = 1'b1;
					end
				end else begin
					st.mismatch_timer = '0;
					if (st.mismatch_indicated) begin
						st.warning_led        = 1'b0;
						st.mismatch_indicated = 1'b0;
					end
				end

				if (!viol && in_tol)
					st.flow_led = 1'b1;
				else
					st.flow_led = ~st.flow_led;

				if (s > SPEED_HIGH) begin
					st.high_speed_timer = tick_up(state_cur.high_speed_timer);
					if (st.high_speed_timer >= HIGH_LIM)
						st.warning_led = 1'b1;
				end else begin
					st.high_speed_timer = '0;
				end

				if (s > SPEED_OVER) begin
					st.over_speed_timer = tick_up(state_cur.over_speed_timer);
					if (st.over_speed_timer >= FLASH_LIM)
						st.warning_flashing = 1'b1;
				end else begin
					st.over_speed_timer = '0;
				end

				if (st.warning_flashing)
					st.warning_led = ~st.warning_led;

				if (s < SPEED_RECOVER && st.warning_flashing) begin
					st.recover_timer = tick_up(state_cur.recover_timer);
					if (st.recover_timer >= FLASH_LIM) begin
						st.warning_led      = 1'b1;
						st.warning_flashing = 1'b0;
					end
				end else begin
					st.recover_timer = '0;
				end

				if (s < SPEED_LOW) begin
					st.low_speed_timer = tick_up(state_cur.low_speed_timer);
					if (st.low_speed_timer >= FLASH_LIM && !st.mismatch_indicated) begin
						st.warning_led      = 1'b0;
						st.warning_flashing = 1'b0;
					end
				end else begin
					st.low_speed_timer = '0;
				end
			end else begin
				st.flow_led    = 1'b0;
				st.warning_led = 1'b0;
			end

			if (item.stop_button)
				res.motor_command = CMD_OFF;
			else if (item.start_button)
				res.motor_command = CMD_ON;
		end
		res.run_led     = st.run_led;
		res.warning_led = st.warning_led;
		res.flow_led    = st.flow_led;
		res.error_led   = st.error_led;
	end

	assign state_nxt = st;
	assign result    = res;

endmodule

// File: rtl/pump_flow_speed_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_flow_speed_supervisor_top
// Pump supervisor: one result per request, registered in and out.
// ----------------------------------------------------------------------------
// A request is taken into an input register, evaluated against the
// supervisor state and written to the result register, so the result
// passes the input register and then the result register before it is
// valid; a new request is taken every cycle as long as the result side
// keeps up, and the single state update per request is what sets that
// rate. The user must write target_flow through cfg_wr_en only while no
// request is in flight; the block itself does not enforce this. 1000 means no target.
module pump_flow_speed_supervisor_top #(
	parameter int unsigned START_TICKS      = pfs_pkg::START_TICKS_DEF,
	parameter int unsigned MISMATCH_TICKS   = pfs_pkg::MISMATCH_TICKS_DEF,
	parameter int unsigned HIGH_SPEED_TICKS = pfs_pkg::HIGH_SPEED_TICKS_DEF,
	parameter int unsigned FLASH_TICKS      = pfs_pkg::FLASH_TICKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pfs_pkg::VAL_W-1:0]         cfg_wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// motor_speed[9:0], flow_rate[19:10], sensor_fault[20], stop_button[21],
	// start_button[22], zero pad
	input  logic [pfs_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// run_led[0], warning_led[1], flow_led[2], error_led[3], sensor_error[4],
	// motor_command[6:5], display_write[7], display_left[12:8],
	// display_right[17:13], zero pad
	output logic [pfs_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import pfs_pkg::*;

	logic [VAL_W-1:0] target_flow_q;
	pfs_item_t        item_s1;
	logic             valid_s1;
	pfs_state_t       state_q;
	pfs_state_t       state_nxt;
	pfs_result_t      result;
	pfs_result_t      result_q;
	logic             out_valid_q;
	logic             advance;
	pfs_item_t        item_in;

	assign item_in.operation    = op_t'(s_tuser);
	assign item_in.motor_speed  = s_tdata[9:0];
	assign item_in.flow_rate    = s_tdata[19:10];
	assign item_in.sensor_fault = s_tdata[20];
	assign item_in.stop_button  = s_tdata[21];
	assign item_in.start_button = s_tdata[22];

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	pfs_step #(
		.START_TICKS      (START_TICKS),
		.MISMATCH_TICKS   (MISMATCH_TICKS),
		.HIGH_SPEED_TICKS (HIGH_SPEED_TICKS),
		.FLASH_TICKS      (FLASH_TICKS)
	) u_step (
		.item        (item_s1),
		.state_cur   (state_q),
		.target_flow (target_flow_q),
		.state_nxt   (state_nxt),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_flow_q <= NO_TARGET;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			state_q       <= '{mode: MODE_IDLE, default: '0};
		end else begin
			if (cfg_wr_en)
				target_flow_q <= cfg_wr_data;
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_in;
		if (advance)
			result_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, result_q.display_right, result_q.display_left,
		result_q.display_write, result_q.motor_command, result_q.sensor_error,
		result_q.error_led, result_q.flow_led, result_q.warning_led, result_q.run_led};

	// state moves only when a request is evaluated
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a request");

	// a request waiting in the input stage is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a request");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_q.motor_command == CMD_NONE ||
			result_q.motor_command == CMD_OFF || result_q.motor_command == CMD_ON))
		else $error("undefined motor command");

	a_display_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !result_q.display_write |->
			result_q.display_left == '0 && result_q.display_right == '0)
		else $error("digits driven without display write");

	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_led |=> state_q.error_led)
		else $error("error led cleared");

endmodule
